FILE: rtl/core/sme_pkg.sv
// Shared types and constants for the stack machine execute block.
// Used by the front end, the back end, the divider and the top level.
// Depends on nothing.
package sme_pkg;

   // Stack and datapath sizes
   localparam int STACK_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);

   // Port field widths
   localparam int OPERATION_W = 3;
   localparam int IMMEDIATE_W = 32;
   localparam int PRINT_W     = 32;
   localparam int FAULT_W     = 2;

   // Raw operation codes on the request port
   localparam logic [OPERATION_W-1:0] OPCODE_HALT  = 3'd0;
   localparam logic [OPERATION_W-1:0] OPCODE_PUSH  = 3'd1;
   localparam logic [OPERATION_W-1:0] OPCODE_ADD   = 3'd2;
   localparam logic [OPERATION_W-1:0] OPCODE_PRINT = 3'd3;
   localparam logic [OPERATION_W-1:0] OPCODE_SUB   = 3'd4;
   localparam logic [OPERATION_W-1:0] OPCODE_MUL   = 3'd5;
   localparam logic [OPERATION_W-1:0] OPCODE_DIV   = 3'd6;

   typedef logic [DATA_WIDTH-1:0] data_type;

   // Decoded operation class
   typedef enum logic [2:0] {
      OPC_HALT,
      OPC_PUSH,
      OPC_ADD,
      OPC_PRINT,
      OPC_SUB,
      OPC_MUL,
      OPC_DIV,
      OPC_NOP
   } op_type;

   // Fault codes on the result port
   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_UNDER   = 2'd1,
      FAULT_DIVZERO = 2'd2,
      FAULT_OVER    = 2'd3
   } fault_type;

   // Execute sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } state_type;

   // Classified request waiting for the back end
   typedef struct packed {
      op_type   op;
      logic     is_binary;
      data_type imm;
   } q_item_type;

   // Result waiting to be popped
   typedef struct packed {
      logic               print_valid;
      logic [PRINT_W-1:0] print_value;
      logic               halted;
      fault_type          fault;
   } rsp_item_type;

endpackage

FILE: rtl/core/sme_front.sv
// Front end: accepts requests, classifies the operation code and queues
// the classified request for the back end (two entries).
// Depends on sme_pkg.
module sme_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic [sme_pkg::OPERATION_W-1:0]          req_operation,
   input  logic signed [sme_pkg::IMMEDIATE_W-1:0]   req_immediate,
   output logic                                     q_valid,
   output sme_pkg::q_item_type                      q_item,
   input  logic                                     q_take
);
   import sme_pkg::*;

   q_item_type q_buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   q_item_type item_in;

   // Classify the operation code
   always_comb begin
      item_in.imm       = DATA_WIDTH'(req_immediate);
      item_in.is_binary = 1'b0;
      unique case (req_operation)
         OPCODE_HALT:  item_in.op = OPC_HALT;
         OPCODE_PUSH:  item_in.op = OPC_PUSH;
         OPCODE_PRINT: item_in.op = OPC_PRINT;
         OPCODE_ADD: begin
            item_in.op        = OPC_ADD;
            item_in.is_binary = 1'b1;
         end
         OPCODE_SUB: begin
            item_in.op        = OPC_SUB;
            item_in.is_binary = 1'b1;
         end
         OPCODE_MUL: begin
            item_in.op        = OPC_MUL;
            item_in.is_binary = 1'b1;
         end
         OPCODE_DIV: begin
            item_in.op        = OPC_DIV;
            item_in.is_binary = 1'b1;
         end
         default:      item_in.op = OPC_NOP;
      endcase
   end

   assign req_full = (cnt_ff == 2'd2);
   assign accept   = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = q_buf_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (accept && !q_take) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!accept && q_take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // Advance queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_take) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (accept) begin
         q_buf_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: rtl/core/sme_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating
// toward zero, wrapping at DATA_WIDTH bits. Divisor must be nonzero.
// Depends on sme_pkg.
module sme_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sme_pkg::data_type dividend,
   input  sme_pkg::data_type divisor,
   output logic              done,
   output sme_pkg::data_type quotient
);
   import sme_pkg::*;

   logic                 busy_ff, done_ff;
   logic [DIV_CNT_W-1:0] steps_ff;
   logic [DATA_WIDTH:0]  rem_ff;
   data_type             quo_ff, den_ff;
   logic                 neg_ff;
   data_type             num_mag, den_mag;
   logic [DATA_WIDTH:0]  shifted;
   logic                 ge;

   // Take magnitudes of the operands
   assign num_mag = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
   assign den_mag = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;

   // One restoring step
   assign shifted = {rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
   assign ge      = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && steps_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Load operands, then shift in one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff   <= num_mag;
         den_ff   <= den_mag;
         rem_ff   <= '0;
         neg_ff   <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         steps_ff <= DIV_CNT_W'(DATA_WIDTH);
      end else if (busy_ff) begin
         rem_ff   <= ge ? (shifted - {1'b0, den_ff}) : shifted;
         quo_ff   <= {quo_ff[DATA_WIDTH-2:0], ge};
         steps_ff <= steps_ff - DIV_CNT_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

FILE: rtl/core/sme_back.sv
// Back end: operand stack memory, execute sequencer, divider and the
// result queue (two entries) that drives the response ports.
// Depends on sme_pkg and sme_div.
module sme_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  sme_pkg::q_item_type           q_item,
   output logic                          q_take,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_print_valid,
   output logic signed [sme_pkg::PRINT_W-1:0] rsp_print_value,
   output logic                          rsp_halted,
   output logic [sme_pkg::FAULT_W-1:0]   rsp_fault
);
   import sme_pkg::*;

   data_type     stack_mem [STACK_DEPTH];
   data_type     top_rd_ff, sec_rd_ff;
   logic [CNT_W-1:0] stack_count_ff, count_in, cnt_m1, cnt_m2;
   logic         halt_ff, halt_in;
   q_item_type   cur_ff;
   state_type    state_ff, state_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   data_type          mem_wdata;

   logic                      div_start, div_done;
   data_type                  div_quot;
   data_type                  prod;
   data_type                  alu_res;

   rsp_item_type rsp_buf_ff [2];
   logic         rsp_wr_ptr_ff, rsp_rd_ptr_ff;
   logic [1:0]   rsp_cnt_ff;
   logic         res_push, res_pop;
   rsp_item_type res_data, rsp_head;

   assign cnt_m1 = stack_count_ff - CNT_W'(1);
   assign cnt_m2 = stack_count_ff - CNT_W'(2);

   // Read top and second entries; data is ready in the execute cycle
   always_ff @(posedge clock) begin
      top_rd_ff <= stack_mem[cnt_m1[ADDR_W-1:0]];
      sec_rd_ff <= stack_mem[cnt_m2[ADDR_W-1:0]];
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Arithmetic on the two operands; the product keeps its low word
   assign prod = sec_rd_ff * top_rd_ff;
   always_comb begin
      case (cur_ff.op)
         OPC_SUB: alu_res = sec_rd_ff - top_rd_ff;
         OPC_MUL: alu_res = prod;
         default: alu_res = sec_rd_ff + top_rd_ff;
      endcase
   end

   sme_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sec_rd_ff),
      .divisor  (top_rd_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stack_count_ff <= '0;
         halt_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= count_in;
         halt_ff        <= halt_in;
      end
   end

   // Hold the request being executed
   always_ff @(posedge clock) begin
      if (q_take) begin
         cur_ff <= q_item;
      end
   end

   // Next state, stack updates and result
   always_comb begin
      state_in             = state_ff;
      count_in             = stack_count_ff;
      halt_in              = halt_ff;
      mem_we               = 1'b0;
      mem_waddr            = cnt_m2[ADDR_W-1:0];
      mem_wdata            = alu_res;
      div_start            = 1'b0;
      q_take               = 1'b0;
      res_push             = 1'b0;
      res_data.print_valid = 1'b0;
      res_data.print_value = '0;
      res_data.halted      = halt_ff;
      res_data.fault       = FAULT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && rsp_cnt_ff != 2'd2) begin
               q_take   = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            res_push = 1'b1;
            if (halt_ff) begin
               // drop: everything after halt is ignored
            end else if (cur_ff.is_binary && stack_count_ff < CNT_W'(2)) begin
               res_data.fault = FAULT_UNDER;
            end else begin
               unique case (cur_ff.op) inside
                  OPC_HALT: begin
                     halt_in         = 1'b1;
                     res_data.halted = 1'b1;
                  end
                  OPC_PUSH: begin
                     if (stack_count_ff == CNT_W'(STACK_DEPTH)) begin
                        res_data.fault = FAULT_OVER;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = stack_count_ff[ADDR_W-1:0];
                        mem_wdata = cur_ff.imm;
                        count_in  = stack_count_ff + CNT_W'(1);
                     end
                  end
                  OPC_PRINT: begin
                     if (stack_count_ff != '0) begin
                        res_data.print_valid = 1'b1;
                        res_data.print_value = PRINT_W'(top_rd_ff);
                     end
                  end
                  OPC_ADD, OPC_SUB, OPC_MUL: begin
                     mem_we   = 1'b1;
                     count_in = cnt_m1;
                  end
                  OPC_DIV: begin
                     if (top_rd_ff == '0) begin
                        res_data.fault = FAULT_DIVZERO;
                     end else begin
                        res_push  = 1'b0;
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  OPC_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_wdata = div_quot;
               count_in  = cnt_m1;
               res_push  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result queue
   assign rsp_empty = (rsp_cnt_ff == 2'd0);
   assign res_pop   = rsp_pop && !rsp_empty;
   assign rsp_head  = rsp_buf_ff[rsp_rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ptr_ff <= 1'b0;
         rsp_rd_ptr_ff <= 1'b0;
         rsp_cnt_ff    <= 2'd0;
      end else begin
         if (res_push) begin
            rsp_wr_ptr_ff <= ~rsp_wr_ptr_ff;
         end
         if (res_pop) begin
            rsp_rd_ptr_ff <= ~rsp_rd_ptr_ff;
         end
         if (res_push && !res_pop) begin
            rsp_cnt_ff <= rsp_cnt_ff + 2'd1;
         end else if (!res_push && res_pop) begin
            rsp_cnt_ff <= rsp_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_buf_ff[rsp_wr_ptr_ff] <= res_data;
      end
   end

   assign rsp_print_valid = rsp_head.print_valid;
   assign rsp_print_value = rsp_head.print_value;
   assign rsp_halted      = rsp_head.halted;
   assign rsp_fault       = rsp_head.fault;

   // Checks
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> $stable(stack_count_ff))
      else $error("stack changed after halt");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> rsp_cnt_ff != 2'd2)
      else $error("result written into a full result queue");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIV)
      else $error("divider started outside the divide wait");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

endmodule

FILE: rtl/core/stack_machine_execute_top.sv
// Top level of the stack machine execute block.
// Instantiates sme_front and sme_back; depends on sme_pkg.
//
// Each request carries one instruction and gives exactly one response, in
// order. In the back end a request first reads the top two stack entries
// from the operand stack memory (registered read), then executes and writes
// back. Divide then waits for the divider, which produces one quotient bit
// per cycle. Up to two requests queue ahead of the back end and up to two
// responses wait to be popped. After halt every request answers with only
// halted set until reset. Stack memory contents need no clearing after
// reset, so requests are accepted from the first cycle.
module stack_machine_execute_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [sme_pkg::OPERATION_W-1:0]        req_operation,
   input  logic signed [sme_pkg::IMMEDIATE_W-1:0] req_immediate,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic                                   rsp_print_valid,
   output logic signed [sme_pkg::PRINT_W-1:0]     rsp_print_value,
   output logic                                   rsp_halted,
   output logic [sme_pkg::FAULT_W-1:0]            rsp_fault
);
   import sme_pkg::*;

   logic       q_valid, q_take;
   q_item_type q_item;

   sme_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_immediate (req_immediate),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_take        (q_take)
   );

   sme_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_take          (q_take),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_print_valid (rsp_print_valid),
      .rsp_print_value (rsp_print_value),
      .rsp_halted      (rsp_halted),
      .rsp_fault       (rsp_fault)
   );

endmodule

FILE: tb/tb_stack_machine_execute_top.sv
// Self-checking testbench for stack_machine_execute_top.
// It runs a directed table, then random instruction streams, and checks every response against
// the table or a shadow model of the operand stack. It depends on sme_pkg and the top level only.
`timescale 1ns / 100ps

module tb_stack_machine_execute_top;
   import sme_pkg::*;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_ITEMS  = 100;
   localparam int SETTLE_WAIT  = 64;
   localparam int MAX_REPORTS  = 10;

   localparam logic [OPERATION_W-1:0] OPCODE_UNUSED = 3'd7;
   localparam data_type WORD_MAX  = 32'h7FFF_FFFF;
   localparam data_type WORD_MIN  = 32'h8000_0000;
   localparam data_type WORD_ONES = 32'hFFFF_FFFF;

   localparam bit TYPED   = 1'b1;
   localparam bit PREDICT = 1'b0;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   typedef struct packed {
      logic [OPERATION_W-1:0] op;
      data_type               imm;
      logic                   typed;
      rsp_item_type           want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_push      = 1'b0;
   logic                   req_full;
   logic [OPERATION_W-1:0] req_operation = OPCODE_PRINT;
   data_type               req_immediate = '0;
   logic                   rsp_empty;
   logic                   rsp_pop       = 1'b0;
   logic                   rsp_print_valid;
   logic signed [PRINT_W-1:0] rsp_print_value;
   logic                   rsp_halted;
   logic [FAULT_W-1:0]     rsp_fault;

   // Side data that travels with the request being offered
   logic                   req_typed = 1'b0;
   rsp_item_type           req_want  = '0;

   // Shadow copy of the block state
   data_type               shadow_stack [STACK_DEPTH];
   int                     shadow_depth  = 0;
   bit                     shadow_halted = 1'b0;

   rsp_item_type           pending_results [$];
   stim_row_type           directed_plan [$];

   int  requests_sent     = 0;
   int  responses_checked = 0;
   int  error_count       = 0;
   int  cycle_count       = 0;
   int  send_idle_pct     = 25;
   int  pop_idle_pct      = 25;
   int  pop_hold          = 0;
   bit  quiet_tail        = 1'b0;

   stack_machine_execute_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_immediate   (req_immediate),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_print_valid (rsp_print_valid),
      .rsp_print_value (rsp_print_value),
      .rsp_halted      (rsp_halted),
      .rsp_fault       (rsp_fault)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got)
         flag_error($sformatf("response %0d %s: expected %h, got %h",
                              responses_checked, name, want, got));
   endfunction

   // Execute one instruction on the shadow stack and return its response
   function automatic rsp_item_type execute_instr(input logic [OPERATION_W-1:0] op,
                                                  input data_type imm);
      rsp_item_type r;
      data_type     top_v, sec_v, res, n_mag, d_mag;
      r = '0;
      if (!shadow_halted) begin
         case (op) inside
            OPCODE_HALT: shadow_halted = 1'b1;
            OPCODE_PUSH: begin
               if (shadow_depth >= STACK_DEPTH) begin
                  r.fault = FAULT_OVER;
               end else begin
                  shadow_stack[shadow_depth] = imm;
                  shadow_depth++;
               end
            end
            OPCODE_PRINT: begin
               if (shadow_depth > 0) begin
                  r.print_valid = 1'b1;
                  r.print_value = shadow_stack[shadow_depth-1];
               end
            end
            OPCODE_ADD, OPCODE_SUB, OPCODE_MUL, OPCODE_DIV: begin
               if (shadow_depth < 2) begin
                  r.fault = FAULT_UNDER;
               end else begin
                  top_v = shadow_stack[shadow_depth-1];
                  sec_v = shadow_stack[shadow_depth-2];
                  if (op == OPCODE_DIV && top_v == '0) begin
                     r.fault = FAULT_DIVZERO;
                  end else begin
                     case (op)
                        OPCODE_ADD: res = sec_v + top_v;
                        OPCODE_SUB: res = sec_v - top_v;
                        OPCODE_MUL: res = sec_v * top_v;
                        default: begin
                           // Divide magnitudes, then restore the sign (truncates toward zero)
                           n_mag = sec_v[DATA_WIDTH-1] ? -sec_v : sec_v;
                           d_mag = top_v[DATA_WIDTH-1] ? -top_v : top_v;
                           res   = n_mag / d_mag;
                           if (sec_v[DATA_WIDTH-1] ^ top_v[DATA_WIDTH-1]) res = -res;
                        end
                     endcase
                     shadow_stack[shadow_depth-2] = res;
                     shadow_depth--;
                  end
               end
            end
            default: ;  // unused opcode does nothing
         endcase
      end
      r.halted = shadow_halted;
      return r;
   endfunction

   function automatic void add_row(input logic [OPERATION_W-1:0] op, input data_type imm,
                                   input bit typed, input logic valid, input data_type value,
                                   input logic halted, input fault_type fault);
      stim_row_type row;
      row.op                = op;
      row.imm               = imm;
      row.typed             = typed;
      row.want.print_valid  = valid;
      row.want.print_value  = value;
      row.want.halted       = halted;
      row.want.fault        = fault;
      directed_plan.insert(directed_plan.size(), row);
   endfunction

   function automatic logic [OPERATION_W-1:0] pick_operation(input int mode);
      int push_pct;
      int roll;
      push_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 12 : 45;
      roll = $urandom_range(0, 99);
      if (roll < 3) return OPCODE_UNUSED;
      if (roll < 3 + push_pct) return OPCODE_PUSH;
      case ($urandom_range(0, 5))
         0:       return OPCODE_PRINT;
         1:       return OPCODE_ADD;
         2:       return OPCODE_SUB;
         3:       return OPCODE_MUL;
         default: return OPCODE_DIV;
      endcase
   endfunction

   // Favor zero, unit values and the extremes so divide corner cases come up often
   function automatic data_type pick_value();
      case ($urandom_range(0, 11))
         0, 1:    return '0;
         2:       return 32'd1;
         3:       return WORD_ONES;
         4:       return WORD_MIN;
         5:       return WORD_MAX;
         6, 7:    return data_type'($urandom_range(0, 40)) - 32'd20;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 40;
      endcase
   endfunction

   // Offer one request, with an optional idle burst first; return at the accepting edge
   task automatic send_request(input logic [OPERATION_W-1:0] op, input data_type imm,
                               input bit typed, input rsp_item_type want);
      if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_operation <= op;
      req_immediate <= imm;
      req_typed     <= typed;
      req_want      <= want;
      do @(posedge clock); while (req_full);
      requests_sent++;
   endtask

   // Hold off new requests until every outstanding response has been popped
   task automatic wait_drained();
      req_push <= 1'b0;
      while (responses_checked != requests_sent) @(posedge clock);
   endtask

   // Result side: pop with random stall bursts, none in the quiet tail
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_pop <= 1'b1;
      end else if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else if ($urandom_range(0, 99) < pop_idle_pct) begin
         pop_hold <= $urandom_range(0, 12);
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Check popped responses, then predict the response for an accepted request
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type outcome;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               flag_error("response popped with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               check_field("print_valid", 32'(want.print_valid), 32'(rsp_print_valid));
               check_field("print_value", want.print_value, rsp_print_value);
               check_field("halted", 32'(want.halted), 32'(rsp_halted));
               check_field("fault", 32'(want.fault), 32'(rsp_fault));
               responses_checked++;
            end
         end
         if (req_push && !req_full) begin
            outcome = execute_instr(req_operation, req_immediate);
            pending_results.insert(pending_results.size(), req_typed ? req_want : outcome);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_stack_machine_execute_top failed");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int      seg_left;
      int      mode;

      // Directed table: empty-stack cases, extremes, every operation but halt, divide corners
      add_row(OPCODE_PRINT,  WORD_ONES, TYPED,   1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_ADD,    WORD_ONES, TYPED,   1'b0, '0,       1'b0, FAULT_UNDER);
      add_row(OPCODE_PUSH,   WORD_MAX,  TYPED,   1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PRINT,  '0,        TYPED,   1'b1, WORD_MAX, 1'b0, FAULT_NONE);
      add_row(OPCODE_SUB,    '0,        TYPED,   1'b0, '0,       1'b0, FAULT_UNDER);
      add_row(OPCODE_DIV,    '0,        TYPED,   1'b0, '0,       1'b0, FAULT_UNDER);
      add_row(OPCODE_PUSH,   WORD_MIN,  TYPED,   1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_ADD,    '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PRINT,  '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PUSH,   '0,        TYPED,   1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_DIV,    WORD_MAX,  TYPED,   1'b0, '0,       1'b0, FAULT_DIVZERO);
      add_row(OPCODE_SUB,    '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PUSH,   WORD_MIN,  TYPED,   1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PUSH,   WORD_ONES, TYPED,   1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_DIV,    '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PRINT,  '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PUSH,   -32'sd7,   PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PUSH,   32'd2,     PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_DIV,    '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_MUL,    '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_UNUSED, 32'h5A5A_A5A5, TYPED, 1'b0, '0,     1'b0, FAULT_NONE);
      add_row(OPCODE_PRINT,  '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_MUL,    '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);
      add_row(OPCODE_PRINT,  '0,        PREDICT, 1'b0, '0,       1'b0, FAULT_NONE);

      // Hold reset, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         send_request(row.op, row.imm, row.typed, row.want);
      end
      wait_drained();

      // Random streams in segments that fill, drain or mix the stack
      seg_left = 0;
      mode     = MODE_MIX;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) wait_drained();
         if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         if (seg_left == 0) begin
            mode          = $urandom_range(MODE_FILL, MODE_MIX);
            seg_left      = $urandom_range(4, 80);
            send_idle_pct = pick_idle_pct();
            pop_idle_pct  = pick_idle_pct();
         end
         seg_left--;
         send_request(pick_operation(mode), pick_value(), PREDICT, '0);
      end
      wait_drained();

      // Halt, then a few requests that must come back with only halted set
      send_request(OPCODE_HALT, pick_value(), TYPED, '{1'b0, '0, 1'b1, FAULT_NONE});
      repeat (6)
         send_request(3'($urandom_range(0, 7)), $urandom, TYPED,
                      '{1'b0, '0, 1'b1, FAULT_NONE});

      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("tb_stack_machine_execute_top passed");
      end else begin
         $display("tb_stack_machine_execute_top failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/sme_pkg.sv
rtl/core/sme_front.sv
rtl/core/sme_div.sv
rtl/core/sme_back.sv
rtl/core/stack_machine_execute_top.sv
tb/tb_stack_machine_execute_top.sv
